// File: rtl/task_table_dedup_engine_top_assert.svh
// Assertion macros shared by the task table RTL.
// Depends on nothing; included by the modules that assert.
`ifndef TASK_TABLE_DEDUP_ENGINE_TOP_ASSERT_SVH
`define TASK_TABLE_DEDUP_ENGINE_TOP_ASSERT_SVH
// Check an implication on every clock edge outside reset.
`define TTD_ASSERT_IMP(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error(msg);
// Check an implication in the cycle after the condition.
`define TTD_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error(msg);
`endif

// File: rtl/ttd_pkg.sv
// Package for the task table: opcodes, status codes, channel payloads, commands.
// Depends on nothing.
`default_nettype none
package ttd_pkg;
   localparam logic [2:0] OP_ADD = 3'd0;
   localparam logic [2:0] OP_ASSIGN = 3'd1;
   localparam logic [2:0] OP_UNASSIGN = 3'd2;
   localparam logic [2:0] OP_DISBAND = 3'd3;
   localparam logic [2:0] OP_QUERY = 3'd4;

   localparam logic [2:0] ST_OK = 3'd0;
   localparam logic [2:0] ST_DUP = 3'd1;
   localparam logic [2:0] ST_FULL = 3'd2;
   localparam logic [2:0] ST_NOTFOUND = 3'd3;
   localparam logic [2:0] ST_WRONG = 3'd4;
   localparam logic [2:0] ST_NONE = 3'd5;

   localparam logic [31:0] ID_MAX = 32'hFFFF_FFFF;

   // Request transaction payload.
   typedef struct packed {
      logic [2:0]  opcode;
      logic [31:0] task_id;
      logic [31:0] desc_crc;
   } ttd_req_type;

   // Response transaction payload.
   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] result_id;
   } ttd_rsp_type;

   // Commands from controller to datapath.
   typedef struct packed {
      logic load;     // capture request, reset scan
      logic step;     // process the slot read last cycle
      logic rd;       // issue a memory read at the pointer, advance pointer
      logic restart;  // restart pointer at home of the new id
      logic commit;   // apply the write and produce the result
   } ttd_cmd_type;

   // Status from datapath to controller.
   typedef struct packed {
      logic last;     // slot being processed is the last of the pass
      logic hit;      // processed slot ends the pass early
   } ttd_sts_type;
endpackage
`default_nettype wire

// File: rtl/ttd_if.sv
// Valid/ready channel interface carrying a generic payload.
// Depends on nothing.
`default_nettype none
interface ttd_if #(parameter type payload_type = logic) ();
   logic valid;
   logic ready;
   payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// File: rtl/ttd_datapath.sv
// Datapath: slot memories, scan pointer, request and result registers.
// Depends on ttd_pkg and the assertion header.
`default_nettype none
`include "task_table_dedup_engine_top_assert.svh"
module ttd_datapath #(
   parameter int TABLE_SLOTS = 256
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire ttd_pkg::ttd_cmd_type cmd,
   output ttd_pkg::ttd_sts_type sts,
   output logic phase_ff,  // 0 first pass, 1 insert probe
   output logic [2:0] op_ff,
   output logic ids_left,
   input  wire logic [2:0] req_opcode,
   input  wire logic [31:0] req_task_id,
   input  wire logic [31:0] req_desc_crc,
   output logic [2:0] rsp_status,
   output logic [31:0] rsp_result_id
);
   localparam int AW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
   localparam logic [AW-1:0] LAST_SLOT = AW'(TABLE_SLOTS - 1);

   // Slot storage; valid bits in flops, the rest in memory.
   logic [TABLE_SLOTS-1:0] valid_ff;
   logic [31:0] id_mem [TABLE_SLOTS];
   logic [31:0] hash_mem [TABLE_SLOTS];
   logic asg_mem [TABLE_SLOTS];
   logic [31:0] rd_id_ff, rd_hash_ff;
   logic rd_asg_ff, rd_valid_ff;

   logic [31:0] key_id_ff, key_hash_ff, last_id_ff, best_ff, new_id_ff;
   logic [AW-1:0] ptr_ff, proc_ff, cnt_ff, pos_ff, last_home_ff;
   logic found_ff, dup_ff, free_ff;
   logic [2:0] status_ff;
   logic [31:0] result_ff;

   logic [AW-1:0] ptr_in, home_new;
   logic [31:0] nid;
   logic slot_hit;
   logic add_ok, add_commit;

   assign nid = last_id_ff + 32'd1;
   // Home slot of the next id follows the id counter, wrapping at the table size.
   assign home_new = (last_home_ff == LAST_SLOT) ? '0 : last_home_ff + AW'(1);
   assign ids_left = (last_id_ff != ttd_pkg::ID_MAX);
   assign add_ok = (op_ff == ttd_pkg::OP_ADD) && free_ff && !dup_ff;
   assign add_commit = cmd.commit && add_ok;

   // Per-slot match for the slot read last cycle.
   always_comb begin
      slot_hit = 1'b0;
      if (!phase_ff) begin
         case (op_ff)
            ttd_pkg::OP_ADD: slot_hit = rd_valid_ff && rd_hash_ff == key_hash_ff;
            ttd_pkg::OP_ASSIGN, ttd_pkg::OP_UNASSIGN, ttd_pkg::OP_DISBAND:
               slot_hit = rd_valid_ff && rd_id_ff == key_id_ff && key_id_ff != 32'd0;
            default: slot_hit = 1'b0;
         endcase
      end else begin
         slot_hit = !rd_valid_ff;
      end
   end
   assign sts.hit = slot_hit;
   assign sts.last = (cnt_ff == LAST_SLOT);
   assign ptr_in = (ptr_ff == LAST_SLOT) ? '0 : ptr_ff + AW'(1);

   // Read port: registered memory read at the pointer.
   always_ff @(posedge clock) begin
      if (cmd.rd) begin
         rd_id_ff <= id_mem[ptr_ff];
         rd_hash_ff <= hash_mem[ptr_ff];
         rd_asg_ff <= asg_mem[ptr_ff];
         rd_valid_ff <= valid_ff[ptr_ff];
         proc_ff <= ptr_ff;
      end
   end

   // Write port: commit updates one slot.
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         if (add_ok) begin
            id_mem[pos_ff] <= new_id_ff;
            hash_mem[pos_ff] <= key_hash_ff;
            asg_mem[pos_ff] <= 1'b0;
         end else if (found_ff && op_ff == ttd_pkg::OP_ASSIGN && !rd_asg_ff) begin
            asg_mem[pos_ff] <= 1'b1;
         end else if (found_ff && op_ff == ttd_pkg::OP_UNASSIGN && rd_asg_ff) begin
            asg_mem[pos_ff] <= 1'b0;
         end
      end
   end

   // Control registers: scan pointer, flags, valid bits, id counter.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         last_id_ff <= '0;
         last_home_ff <= '0;
         phase_ff <= 1'b0;
         found_ff <= 1'b0;
         dup_ff <= 1'b0;
         free_ff <= 1'b0;
         ptr_ff <= '0;
         cnt_ff <= '0;
      end else begin
         // Advance the pointer with every slot read.
         if (cmd.rd) ptr_ff <= ptr_in;
         // Load starts the first pass at slot 0; queries walk every slot, the insert probe starts at the new id's home.
         if (cmd.load) begin
            op_ff <= req_opcode;
            key_id_ff <= req_task_id;
            key_hash_ff <= req_desc_crc;
            ptr_ff <= '0;
            cnt_ff <= '0;
            phase_ff <= 1'b0;
            found_ff <= 1'b0;
            dup_ff <= 1'b0;
            free_ff <= 1'b0;
         end
         if (cmd.step) begin
            cnt_ff <= cnt_ff + AW'(1);
            if (slot_hit) begin
               pos_ff <= proc_ff;
               if (phase_ff) free_ff <= 1'b1;
               else if (op_ff == ttd_pkg::OP_ADD) dup_ff <= 1'b1;
               else found_ff <= 1'b1;
            end
            // Track the smallest pending id for the query.
            if (op_ff == ttd_pkg::OP_QUERY && rd_valid_ff && !rd_asg_ff &&
                (!found_ff || rd_id_ff < best_ff)) begin
               best_ff <= rd_id_ff;
               found_ff <= 1'b1;
            end
         end
         if (cmd.restart) begin
            phase_ff <= 1'b1;
            ptr_ff <= home_new;
            cnt_ff <= '0;
            new_id_ff <= nid;
         end
         if (cmd.commit) begin
            if (add_ok) begin
               valid_ff[pos_ff] <= 1'b1;
               last_id_ff <= new_id_ff;
               last_home_ff <= home_new;
            end else if (found_ff && op_ff == ttd_pkg::OP_DISBAND) begin
               valid_ff[pos_ff] <= 1'b0;
            end
         end
      end
   end

   // Result formation at commit; rd_asg_ff holds the found slot's mark.
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         result_ff <= '0;
         case (op_ff)
            ttd_pkg::OP_ADD: begin
               if (dup_ff) status_ff <= ttd_pkg::ST_DUP;
               else if (!free_ff) status_ff <= ttd_pkg::ST_FULL;
               else begin
                  status_ff <= ttd_pkg::ST_OK;
                  result_ff <= new_id_ff;
               end
            end
            ttd_pkg::OP_ASSIGN: status_ff <= !found_ff ? ttd_pkg::ST_NOTFOUND :
               (rd_asg_ff ? ttd_pkg::ST_WRONG : ttd_pkg::ST_OK);
            ttd_pkg::OP_UNASSIGN: status_ff <= !found_ff ? ttd_pkg::ST_NOTFOUND :
               (!rd_asg_ff ? ttd_pkg::ST_WRONG : ttd_pkg::ST_OK);
            ttd_pkg::OP_DISBAND: status_ff <= !found_ff ? ttd_pkg::ST_NOTFOUND :
               ttd_pkg::ST_OK;
            ttd_pkg::OP_QUERY: begin
               if (found_ff) begin
                  status_ff <= ttd_pkg::ST_OK;
                  result_ff <= best_ff;
               end else status_ff <= ttd_pkg::ST_NONE;
            end
            default: status_ff <= ttd_pkg::ST_WRONG;
         endcase
      end
   end

   assign rsp_status = status_ff;
   assign rsp_result_id = result_ff;

   `TTD_ASSERT_IMP(a_probe_ok, clock, reset, cmd.restart, !dup_ff && ids_left, "bad probe start")
   `TTD_ASSERT_NEXT(a_id_grows, clock, reset, add_commit, last_id_ff == $past(new_id_ff), "id off")
   `TTD_ASSERT_IMP(a_one_cmd, clock, reset, 1'b1, $onehot0({cmd.load, cmd.restart, cmd.commit}), "clash")
endmodule
`default_nettype wire

// File: rtl/ttd_ctrl.sv
// Controller state machine: sequences load, slot scan, probe and commit.
// Depends on ttd_pkg and the assertion header.
`default_nettype none
`include "task_table_dedup_engine_top_assert.svh"
module ttd_ctrl (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic req_ready,
   output logic rsp_valid,
   input  wire logic rsp_ready,
   input  wire logic [2:0] op,
   input  wire logic ids_left,
   input  wire logic phase,
   input  wire ttd_pkg::ttd_sts_type sts,
   output ttd_pkg::ttd_cmd_type cmd
);
   typedef enum logic [5:0] {
      S_IDLE = 6'b000001, S_PRIME = 6'b000010, S_SCAN = 6'b000100,
      S_DECIDE = 6'b001000, S_COMMIT = 6'b010000, S_WAIT = 6'b100000
   } state_type;
   state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic scans;

   // Opcodes past query need no scan.
   assign scans = (op == ttd_pkg::OP_ADD) || (op == ttd_pkg::OP_ASSIGN) ||
      (op == ttd_pkg::OP_UNASSIGN) || (op == ttd_pkg::OP_DISBAND) ||
      (op == ttd_pkg::OP_QUERY);

   // Accept a new transaction once the previous result is gone or going.
   assign req_ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         S_IDLE: if (req_valid && req_ready) begin
            cmd.load = 1'b1;
            state_in = S_PRIME;
         end
         S_PRIME: begin
            cmd.rd = 1'b1;
            state_in = scans ? S_SCAN : S_COMMIT;
         end
         S_SCAN: begin
            cmd.step = 1'b1;
            if ((sts.hit && op != ttd_pkg::OP_QUERY) || sts.last) state_in = S_DECIDE;
            else cmd.rd = 1'b1;
         end
         S_DECIDE: begin
            // After an add's duplicate pass finds no duplicate and ids remain, probe for a free slot.
            if (op == ttd_pkg::OP_ADD && !phase && !sts.hit && ids_left) begin
               cmd.restart = 1'b1;
               state_in = S_PRIME;
            end else state_in = S_COMMIT;
         end
         S_COMMIT: if (!rsp_valid_ff || rsp_ready) begin
            cmd.commit = 1'b1;
            rsp_valid_in = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `TTD_ASSERT_NEXT(a_commit_valid, clock, reset, cmd.commit, rsp_valid_ff, "commit without result")
   `TTD_ASSERT_IMP(a_accept_idle, clock, reset, cmd.load, state_ff == S_IDLE, "load outside idle")
   `TTD_ASSERT_IMP(a_step_scan, clock, reset, cmd.step, state_ff == S_SCAN, "step outside scan")
endmodule
`default_nettype wire

// File: rtl/task_table_dedup_engine_top.sv
// Top level of the task table: channels, controller and datapath.
// Depends on ttd_pkg, ttd_if, ttd_ctrl, ttd_datapath.
`default_nettype none
// Task table with duplicate refusal. One transaction at a time: an add reads
// up to TABLE_SLOTS slots for a duplicate hash, then, if none is found, probes
// from the new id's home slot (kept as a counter beside the id counter) for a
// free one; assign/unassign/disband read from slot 0 until the id is found (up
// to TABLE_SLOTS slots); a query reads all slots. One slot is read per cycle.
// The controller goes back to idle after each result before it accepts the
// next transaction. A result held off by the receiver blocks the next
// acceptance. No clearing pass is needed after reset. One result per request.
module task_table_dedup_engine_top #(
   parameter int TABLE_SLOTS = 256
) (
   input wire logic clock,
   input wire logic reset,
   ttd_if.sink req,
   ttd_if.source rsp
);
   ttd_pkg::ttd_cmd_type cmd;
   ttd_pkg::ttd_sts_type sts;
   logic phase;
   logic [2:0] op_q;
   logic ids_left;

   ttd_ctrl ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req.valid), .req_ready(req.ready),
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
      .op(op_q), .ids_left(ids_left), .phase(phase),
      .sts(sts), .cmd(cmd)
   );

   ttd_datapath #(.TABLE_SLOTS(TABLE_SLOTS)) dp (
      .clock(clock), .reset(reset), .cmd(cmd), .sts(sts), .phase_ff(phase),
      .op_ff(op_q), .ids_left(ids_left),
      .req_opcode(req.payload.opcode), .req_task_id(req.payload.task_id),
      .req_desc_crc(req.payload.desc_crc),
      .rsp_status(rsp.payload.status), .rsp_result_id(rsp.payload.result_id)
   );
endmodule
`default_nettype wire

// File: tb/sv/tb.sv
// Self-checking testbench for task_table_dedup_engine_top: random and directed
// requests, a per-transaction predictor of the task table, and a response checker.
// Depends on ttd_pkg, ttd_if and the RTL of task_table_dedup_engine_top.
`default_nettype none
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SLOTS = 256;
   localparam int RANDOM_ITEMS = 1400;

   logic clock = 1'b0;
   logic reset = 1'b1;

   ttd_if #(.payload_type(ttd_pkg::ttd_req_type)) req_ch ();
   ttd_if #(.payload_type(ttd_pkg::ttd_rsp_type)) rsp_ch ();

   task_table_dedup_engine_top #(.TABLE_SLOTS(SLOTS)) dut (
      .clock(clock),
      .reset(reset),
      .req(req_ch.sink),
      .rsp(rsp_ch.source)
   );

   always #10 clock = ~clock;

   // Shadow copy of the task table
   logic        tbl_valid [SLOTS];
   logic [31:0] tbl_id [SLOTS];
   logic [31:0] tbl_hash [SLOTS];
   logic        tbl_assigned [SLOTS];
   logic [31:0] newest_id;

   ttd_pkg::ttd_req_type pending_reqs[$];
   ttd_pkg::ttd_rsp_type expected_rsps[$];
   int      error_count = 0;
   int      accepted_reqs = 0;
   int      gen_adds = 0;
   bit      stim_done = 0;

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch: %s got %0h expected %0h at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   function automatic int find_slot(input logic [31:0] id);
      int found;
      found = -1;
      if (id != 0) begin
         for (int k = 0; k < SLOTS; k++) begin
            int s;
            s = (id % SLOTS + k) % SLOTS;
            if (found < 0 && tbl_valid[s] && tbl_id[s] == id) found = s;
         end
      end
      return found;
   endfunction

   // Compute the response to one request and update the shadow table
   function automatic ttd_pkg::ttd_rsp_type update_table(input ttd_pkg::ttd_req_type r);
      ttd_pkg::ttd_rsp_type e;
      int      pos;
      bit      hit;
      logic [31:0] nid;
      e.status = ttd_pkg::ST_OK;
      e.result_id = '0;
      case (r.opcode)
         ttd_pkg::OP_ADD: begin
            hit = 0;
            for (int s = 0; s < SLOTS; s++)
               if (tbl_valid[s] && tbl_hash[s] == r.desc_crc) hit = 1;
            if (hit) begin
               e.status = ttd_pkg::ST_DUP;
            end else if (newest_id == ttd_pkg::ID_MAX) begin
               e.status = ttd_pkg::ST_FULL;
            end else begin
               nid = newest_id + 32'd1;
               pos = -1;
               for (int k = 0; k < SLOTS; k++) begin
                  int t;
                  t = (nid % SLOTS + k) % SLOTS;
                  if (pos < 0 && !tbl_valid[t]) pos = t;
               end
               if (pos < 0) begin
                  e.status = ttd_pkg::ST_FULL;
               end else begin
                  newest_id = nid;
                  tbl_valid[pos] = 1'b1;
                  tbl_id[pos] = nid;
                  tbl_hash[pos] = r.desc_crc;
                  tbl_assigned[pos] = 1'b0;
                  e.result_id = nid;
               end
            end
         end
         ttd_pkg::OP_ASSIGN, ttd_pkg::OP_UNASSIGN, ttd_pkg::OP_DISBAND: begin
            pos = find_slot(r.task_id);
            if (pos < 0) begin
               e.status = ttd_pkg::ST_NOTFOUND;
            end else if (r.opcode == ttd_pkg::OP_ASSIGN) begin
               if (tbl_assigned[pos]) e.status = ttd_pkg::ST_WRONG;
               else tbl_assigned[pos] = 1'b1;
            end else if (r.opcode == ttd_pkg::OP_UNASSIGN) begin
               if (!tbl_assigned[pos]) e.status = ttd_pkg::ST_WRONG;
               else tbl_assigned[pos] = 1'b0;
            end else begin
               tbl_valid[pos] = 1'b0;
            end
         end
         ttd_pkg::OP_QUERY: begin
            hit = 0;
            nid = '0;
            for (int s = 0; s < SLOTS; s++)
               if (tbl_valid[s] && !tbl_assigned[s] && (!hit || tbl_id[s] < nid)) begin
                  nid = tbl_id[s];
                  hit = 1;
               end
            if (hit) e.result_id = nid;
            else e.status = ttd_pkg::ST_NONE;
         end
         default: e.status = ttd_pkg::ST_WRONG;
      endcase
      return e;
   endfunction

   function automatic void push_req(input logic [2:0] op, input logic [31:0] id,
                                    input logic [31:0] h);
      ttd_pkg::ttd_req_type r;
      r.opcode = op;
      r.task_id = id;
      r.desc_crc = h;
      pending_reqs.push_back(r);
      if (op == ttd_pkg::OP_ADD) gen_adds++;
   endfunction

   function automatic logic [31:0] pick_id();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return $urandom;
         default: return $urandom_range(1, gen_adds + 1);
      endcase
   endfunction

   function automatic logic [31:0] pick_hash();
      if ($urandom_range(0, 7) == 0) return $urandom;
      return $urandom_range(0, 40);
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 93) return $urandom_range(1, 4);
      return $urandom_range(20, 80);
   endfunction

   // Fill the request queue: directed part, table fill, then random traffic
   initial begin
      int op_pick;
      for (int s = 0; s < SLOTS; s++) tbl_valid[s] = 1'b0;
      newest_id = '0;
      push_req(ttd_pkg::OP_QUERY, 32'd0, 32'd0);
      push_req(ttd_pkg::OP_ASSIGN, 32'd0, 32'd0);
      push_req(ttd_pkg::OP_UNASSIGN, 32'hFFFF_FFFF, 32'd0);
      push_req(ttd_pkg::OP_DISBAND, 32'd1, 32'd0);
      push_req(ttd_pkg::OP_ADD, 32'd0, 32'h0000_0000);
      push_req(ttd_pkg::OP_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      push_req(ttd_pkg::OP_ADD, 32'd0, 32'hFFFF_FFFF);
      push_req(ttd_pkg::OP_QUERY, 32'd0, 32'd0);
      push_req(ttd_pkg::OP_ASSIGN, 32'd1, 32'd0);
      push_req(ttd_pkg::OP_ASSIGN, 32'd1, 32'd0);
      push_req(ttd_pkg::OP_QUERY, 32'd0, 32'd0);
      push_req(ttd_pkg::OP_UNASSIGN, 32'd2, 32'd0);
      push_req(ttd_pkg::OP_UNASSIGN, 32'd1, 32'd0);
      push_req(ttd_pkg::OP_ASSIGN, 32'd1, 32'd0);
      push_req(ttd_pkg::OP_ASSIGN, 32'd2, 32'd0);
      push_req(ttd_pkg::OP_QUERY, 32'd0, 32'd0);
      push_req(ttd_pkg::OP_DISBAND, 32'd1, 32'd0);
      push_req(ttd_pkg::OP_DISBAND, 32'd1, 32'd0);
      push_req(ttd_pkg::OP_DISBAND, 32'd2, 32'd0);
      push_req(3'd5, 32'd1, 32'd1);
      push_req(3'd6, 32'd2, 32'd2);
      push_req(3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      // Fill the table completely, overflow it, then punch holes and refill
      for (int i = 0; i < SLOTS + 2; i++)
         push_req(ttd_pkg::OP_ADD, 32'd0, 32'h8000_0000 + i);
      for (int i = 0; i < 6; i++)
         push_req(ttd_pkg::OP_DISBAND, $urandom_range(3, SLOTS + 2), 32'd0);
      for (int i = 0; i < 8; i++)
         push_req(ttd_pkg::OP_ADD, 32'd0, 32'h9000_0000 + i);
      for (int i = 0; i < 12; i++) push_req(ttd_pkg::OP_QUERY, 32'd0, 32'd0);
      for (int i = 0; i < SLOTS; i++) push_req(ttd_pkg::OP_DISBAND, gen_adds - i, 32'd0);
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         op_pick = $urandom_range(0, 99);
         if (op_pick < 35) push_req(ttd_pkg::OP_ADD, $urandom, pick_hash());
         else if (op_pick < 52) push_req(ttd_pkg::OP_ASSIGN, pick_id(), $urandom);
         else if (op_pick < 66) push_req(ttd_pkg::OP_UNASSIGN, pick_id(), $urandom);
         else if (op_pick < 84) push_req(ttd_pkg::OP_DISBAND, pick_id(), $urandom);
         else if (op_pick < 97) push_req(ttd_pkg::OP_QUERY, $urandom, $urandom);
         else push_req(3'($urandom_range(5, 7)), $urandom, $urandom);
      end
      stim_done = 1;
   end

   // Hold reset from time zero, then release it on a clock edge
   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
   end

   // Driver: offer queued transactions with random gaps, predict on acceptance
   int req_gap = 0;
   always @(posedge clock) begin
      ttd_pkg::ttd_req_type nxt;
      bit      load;
      if (reset) begin
         req_ch.valid <= 1'b0;
         req_ch.payload <= '0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            expected_rsps.push_back(update_table(req_ch.payload));
            accepted_reqs++;
            req_gap = (accepted_reqs % 400 < 60) ? 0 : pick_gap();
         end
         if (!req_ch.valid || req_ch.ready) begin
            load = 0;
            if (req_gap > 0) begin
               req_gap--;
            end else if (pending_reqs.size() > 0) begin
               nxt = pending_reqs.pop_front();
               load = 1;
            end
            req_ch.valid <= load;
            if (load) req_ch.payload <= nxt;
         end
      end
   end

   // Receiver: random stalls, plus one long hold-off to back up the input
   int  hold_cycles = 0;
   bit  long_hold_done = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (hold_cycles > 0) begin
         hold_cycles--;
         rsp_ch.ready <= 1'b0;
      end else if (!long_hold_done && accepted_reqs == 300) begin
         long_hold_done = 1;
         hold_cycles = 3000;
         rsp_ch.ready <= 1'b0;
      end else if ($urandom_range(0, 99) < 12 && accepted_reqs % 400 >= 60) begin
         hold_cycles = pick_gap();
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   // Monitor: compare each response with the oldest expectation
   always @(posedge clock) begin
      ttd_pkg::ttd_rsp_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_rsps.size() == 0) begin
            report_mismatch("unexpected response", rsp_ch.payload.result_id, 32'd0);
         end else begin
            want = expected_rsps.pop_front();
            if (rsp_ch.payload.status !== want.status)
               report_mismatch("status", 32'(rsp_ch.payload.status), 32'(want.status));
            if (rsp_ch.payload.result_id !== want.result_id)
               report_mismatch("result_id", rsp_ch.payload.result_id, want.result_id);
         end
      end
   end

   // End of run: drain, allow the block's latency, then judge
   initial begin
      wait (stim_done);
      @(posedge clock);
      while (pending_reqs.size() > 0 || req_ch.valid || expected_rsps.size() > 0)
         @(posedge clock);
      repeat (2 * SLOTS + 20) @(posedge clock);
      if (expected_rsps.size() > 0) error_count++;
      if (error_count == 0) begin
         $display("tb passed");
      end else begin
         $display("tb failed");
      end
      $finish;
   end

   // Hard limit on simulated time
   initial begin
      #200000000;
      $display("tb failed");
      $finish;
   end
endmodule
`default_nettype wire

// File: task_table_dedup_engine_top.f
+incdir+rtl
rtl/ttd_pkg.sv
rtl/ttd_if.sv
rtl/ttd_datapath.sv
rtl/ttd_ctrl.sv
rtl/task_table_dedup_engine_top.sv
tb/sv/tb.sv
